// File: rtl/gcse_pkg.sv
// shared types and constants for the graph contract/split engine
package gcse_pkg;

  localparam int MaxVerticesDefault = 32;
  localparam int VertexWidth = 5;
  localparam int CountWidth = 6;
  localparam logic [CountWidth-1:0] StartReset = 6'd32;

  typedef enum logic [2:0] {
    CMD_INIT     = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_QUERY    = 3'd3,
    CMD_MERGE    = 3'd4,
    CMD_CONTRACT = 3'd5,
    CMD_SPLIT    = 3'd6,
    CMD_NONE     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [VertexWidth-1:0] first_vertex;
    logic [VertexWidth-1:0] second_vertex;
  } in_word_t;

  typedef struct packed {
    logic                  edge_present;
    logic [CountWidth-1:0] vertex_count;
    logic [1:0]            status;
  } out_word_t;

endpackage

// File: rtl/graph_contract_split_engine_top.sv
// top level of the graph contract/split engine: sequencer around a row memory
//
//  channel | ports                          | handshake
//  in      | start, busy, in_word           | taken when start && !busy
//  out     | out_strobe, out_word           | one-cycle strobe, no backpressure
//  cfg     | cfg_valid, cfg_ready, cfg_data | write when cfg_valid && cfg_ready
//
// after reset a clearing pass writes zero to every row, busy high
// init also sweeps all rows, busy high
// add/remove step through read u, read v, write u, write v, done; query through read u, read v, done
// merge/contract/split sweep the live rows through the single memory port
//   (each live row is read once and written back at most once)
// the result strobe comes in the cycle after the done cycle; the receiver cannot stall
module graph_contract_split_engine_top
  import gcse_pkg::*;
#(
  parameter int MaxVertices = MaxVerticesDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_strobe,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CountWidth-1:0] cfg_data
);

  localparam int AW = $clog2(MaxVertices);
  localparam int NW = $clog2(MaxVertices + 1);
  localparam logic [NW-1:0] MaxN = NW'(MaxVertices);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_U, S_RD_V, S_WR_U, S_WR_V,
    S_SCAN_RD, S_SCAN_WR, S_FIN_A, S_FIN_B, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [CountWidth-1:0] start_r;
  logic [NW-1:0]         live_r, live_nxt;
  cmd_t                  cmd_r;
  logic [AW-1:0]         u_r, v_r;
  logic [MaxVertices-1:0] row_u_r, row_v_r;
  logic [AW:0]           idx_r, idx_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  present_r, present_nxt;
  logic                  stall_r;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [MaxVertices-1:0] wr_data, rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  gcse_row_mem #(.Depth(MaxVertices), .AddrWidth(AW)) u_mem (
    .clk, .wr_en, .wr_addr, .wr_data,
    .rd_en, .rd_addr, .rd_data
  );

  // vertices supplied as 5 bits; at or beyond the live count is invalid
  logic [NW+4:0] u_ext, v_ext;
  logic in_valid_u, in_valid_v;
  assign u_ext = (NW+5)'(in_word.first_vertex);
  assign v_ext = (NW+5)'(in_word.second_vertex);
  assign in_valid_u = u_ext < (NW+5)'(live_r);
  assign in_valid_v = v_ext < (NW+5)'(live_r);

  // bit helpers
  function automatic logic [MaxVertices-1:0] bit_at(input logic [AW:0] i);
    logic [MaxVertices-1:0] b;
    b = '0;
    if (i < (AW+1)'(MaxVertices)) b[i[AW-1:0]] = 1'b1;
    return b;
  endfunction

  function automatic logic [MaxVertices-1:0] drop_bit(input logic [MaxVertices-1:0] x,
                                                       input logic [AW-1:0] v);
    logic [MaxVertices-1:0] lowm;
    lowm = bit_at((AW+1)'(v)) - 1'b1;
    return (x & lowm) | ((x >> 1) & ~lowm);
  endfunction

  localparam logic [MaxVertices-1:0] EvenMask = MaxVertices'({(MaxVertices+1)/2{2'b01}});

  logic [AW:0] scan_i;
  logic [MaxVertices-1:0] bu, bv, bn, joined, ev, od, rowx;
  assign scan_i = idx_r - 1'b1;          // row returned by the memory in S_SCAN_WR
  assign bu = bit_at((AW+1)'(u_r));
  assign bv = bit_at((AW+1)'(v_r));
  assign bn = bit_at((AW+1)'(live_r));
  assign joined = (row_u_r | row_v_r) & ~(bu | bv);
  assign ev = row_v_r & ~bv & EvenMask;
  assign od = row_v_r & ~bv & ~EvenMask;

  logic is_merge;
  assign is_merge = (cmd_r == CMD_MERGE) || (cmd_r == CMD_CONTRACT);

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // memory control and next-state logic
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rowx = rd_data;
    idx_nxt = idx_r;
    state_nxt = state_r;
    live_nxt = live_r;
    status_nxt = status_r;
    present_nxt = present_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(MaxVertices - 1)) state_nxt = S_DONE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        rd_en = 1'b1;
        rd_addr = AW'(in_word.first_vertex);
      end
      S_RD_U: begin
        // rd_data is row u
        rd_en = 1'b1;
        rd_addr = v_r;
        state_nxt = S_RD_V;
      end
      S_RD_V: begin
        // row_u_r holds row u, rd_data is row v
        present_nxt = (cmd_r == CMD_QUERY) && ((row_u_r & bv) != '0);
        unique case (cmd_r)
          CMD_ADD, CMD_REMOVE: state_nxt = S_WR_U;
          CMD_QUERY: state_nxt = S_DONE;
          CMD_CONTRACT: begin
            if ((row_u_r & bv) == '0) begin
              status_nxt = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_WR_U;
            end
          end
          default: state_nxt = S_WR_U;
        endcase
      end
      S_WR_U: begin
        // rd_data is row v, row_u_r holds row u
        unique case (cmd_r)
          CMD_ADD, CMD_REMOVE: begin
            wr_en = 1'b1;
            wr_addr = u_r;
            wr_data = (cmd_r == CMD_ADD) ? (row_u_r | bv) : (row_u_r & ~bv);
            state_nxt = S_WR_V;
          end
          default: begin
            // merge/contract/split: start the row sweep
            rd_en = 1'b1;
            rd_addr = '0;
            idx_nxt = (AW+1)'(1);
            state_nxt = S_SCAN_WR;
          end
        endcase
      end
      S_WR_V: begin
        wr_en = 1'b1;
        wr_addr = v_r;
        wr_data = (cmd_r == CMD_ADD) ? (row_v_r | bu) : (row_v_r & ~bu);
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        rd_en = 1'b1;
        rd_addr = idx_r[AW-1:0];
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SCAN_WR;
      end
      S_SCAN_WR: begin
        // rd_data is row scan_i; rows written at or below scan_i never read again
        if (is_merge) begin
          if (scan_i[AW-1:0] == u_r) begin
            rowx = joined;
          end else begin
            rowx = rd_data | (((rd_data & bv) != '0) ? bu : '0);
          end
          wr_en = (scan_i[AW-1:0] != v_r);
          wr_addr = (scan_i > (AW+1)'(v_r)) ? AW'(scan_i - 1'b1) : scan_i[AW-1:0];
          wr_data = drop_bit(rowx, v_r);
        end else begin
          wr_en = ((ev & bit_at(scan_i)) != '0);
          wr_addr = scan_i[AW-1:0];
          wr_data = (rd_data & ~bv) | bn;
        end
        if (idx_r >= (AW+1)'(live_r)) state_nxt = S_FIN_A;
        else state_nxt = S_SCAN_RD;
      end
      S_FIN_A: begin
        wr_en = 1'b1;
        if (is_merge) begin
          wr_addr = AW'(live_r - 1'b1);
          wr_data = '0;
          live_nxt = live_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          wr_addr = v_r;
          wr_data = od | bn;
          state_nxt = S_FIN_B;
        end
      end
      S_FIN_B: begin
        wr_en = 1'b1;
        wr_addr = AW'(live_r);
        wr_data = ev | bv;
        live_nxt = live_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      start_r <= StartReset;
      live_r <= (int'(StartReset) > MaxVertices) ? MaxN : NW'(StartReset);
      idx_r <= '0;
      status_r <= ST_DONE;
      present_r <= 1'b0;
      stall_r <= 1'b1;
      out_strobe <= 1'b0;
      cmd_r <= CMD_NONE;
    end else begin
      if (cfg_valid && cfg_ready) start_r <= cfg_data;
      out_strobe <= 1'b0;
      idx_r <= idx_nxt;
      live_r <= live_nxt;
      status_r <= status_nxt;
      present_r <= present_nxt;
      state_r <= state_nxt;
      if (state_r == S_DONE) begin
        out_strobe <= !stall_r;
        stall_r <= 1'b0;
      end
      if (state_r == S_RD_U) row_u_r <= rd_data;
      if (state_r == S_WR_U) row_v_r <= rd_data;
      if (state_r == S_IDLE && start) begin
        cmd_r <= cmd_t'(in_word.cmd);
        u_r <= AW'(in_word.first_vertex);
        v_r <= AW'(in_word.second_vertex);
        status_r <= ST_DONE;
        present_r <= 1'b0;
        unique case (cmd_t'(in_word.cmd))
          CMD_INIT: begin
            idx_r <= '0;
            live_r <= (int'(start_r) > MaxVertices) ? MaxN : NW'(start_r);
            state_r <= S_CLEAR;
          end
          CMD_ADD, CMD_MERGE, CMD_CONTRACT: begin
            if (!in_valid_u || !in_valid_v ||
                in_word.first_vertex == in_word.second_vertex) begin
              status_r <= ST_INVALID;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD_U;
            end
          end
          CMD_REMOVE, CMD_QUERY: begin
            if (!in_valid_u || !in_valid_v) begin
              status_r <= ST_INVALID;
              state_r <= S_DONE;
            end else if (in_word.first_vertex == in_word.second_vertex) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RD_U;
            end
          end
          CMD_SPLIT: begin
            if (!in_valid_v) begin
              status_r <= ST_INVALID;
              state_r <= S_DONE;
            end else if (live_r >= MaxN) begin
              status_r <= ST_FULL;
              state_r <= S_DONE;
            end else begin
              u_r <= AW'(in_word.second_vertex);
              state_r <= S_RD_U;
            end
          end
          default: begin
            status_r <= ST_INVALID;
            state_r <= S_DONE;
          end
        endcase
      end
    end
  end

  // split only uses row v, read in S_RD_U and held in row_v_r; row_u_r is not used there

  always_comb begin
    out_word.edge_present = present_r;
    out_word.vertex_count = CountWidth'(live_r);
    out_word.status = status_r;
  end

`ifndef SYNTH
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= MaxN) else $error("live count above capacity");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_DONE) else $error("strobe outside done");
  a_merge_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_A && is_merge) |=> live_r == $past(live_r) - 1'b1)
    else $error("merge count slip");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD) |-> busy) else $error("accept during sweep");
`endif

endmodule

// File: rtl/gcse_row_mem.sv
// adjacency row memory, one write port, one registered read port
module gcse_row_mem
  import gcse_pkg::*;
#(
  parameter int Depth = MaxVerticesDefault,
  parameter int AddrWidth = $clog2(Depth)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AddrWidth-1:0] wr_addr,
  input  logic [Depth-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [AddrWidth-1:0] rd_addr,
  output logic [Depth-1:0]     rd_data
);

  logic [Depth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: verif/graph_contract_split_engine_top_tb.sv
// self-checking testbench for the graph contract/split engine top level
module graph_contract_split_engine_top_tb;
  import gcse_pkg::*;

  localparam int NV = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_strobe;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CountWidth-1:0] cfg_data;

  graph_contract_split_engine_top #(.MaxVertices(NV)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predicted graph: symmetric adjacency rows plus live count
  logic [NV-1:0] adj_rows [NV];
  int unsigned live_count;
  int unsigned start_count;
  out_word_t expected_words[$];
  int error_count;
  int idle_cycles;
  bit quiet_sender;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // merge v into u, renumbering vertices above v down by one
  function automatic void graph_merge(int unsigned u, int unsigned v);
    logic [NV-1:0] fresh [NV];
    logic [NV-1:0] r;
    int unsigned n;
    n = live_count;
    for (int i = 0; i < NV; i++) fresh[i] = '0;
    for (int i = 0; i < n; i++) begin
      if (i == v) continue;
      if (i == u) begin
        r = adj_rows[u] | adj_rows[v];
        r[u] = 1'b0;
        r[v] = 1'b0;
      end else begin
        r = adj_rows[i];
        if (r[v]) r[u] = 1'b1;
      end
      // drop bit v
      for (int j = 0; j < NV; j++) begin
        if (j < v) fresh[(i < v) ? i : i - 1][j] = r[j];
        else if (j + 1 < NV) fresh[(i < v) ? i : i - 1][j] = r[j+1];
      end
    end
    for (int i = 0; i < NV; i++) adj_rows[i] = fresh[i];
    live_count = n - 1;
  endfunction

  // new vertex n takes the even neighbours of v
  function automatic void graph_split(int unsigned v);
    logic [NV-1:0] r, ev, od;
    int unsigned n;
    n = live_count;
    r = adj_rows[v];
    r[v] = 1'b0;
    for (int j = 0; j < NV; j++) begin
      ev[j] = (j % 2 == 0) ? r[j] : 1'b0;
      od[j] = (j % 2 == 1) ? r[j] : 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (ev[i]) begin
        adj_rows[i][v] = 1'b0;
        adj_rows[i][n] = 1'b1;
      end
    end
    adj_rows[v] = od;
    adj_rows[v][n] = 1'b1;
    adj_rows[n] = ev;
    adj_rows[n][v] = 1'b1;
    live_count = n + 1;
  endfunction

  function automatic out_word_t predict_graph_step(in_word_t w);
    out_word_t o;
    int unsigned u, v;
    bit ok;
    u = w.first_vertex;
    v = w.second_vertex;
    ok = (u < live_count) && (v < live_count);
    o.edge_present = 1'b0;
    o.status = ST_DONE;
    case (cmd_t'(w.cmd))
      CMD_INIT: begin
        for (int i = 0; i < NV; i++) adj_rows[i] = '0;
        live_count = (start_count > NV) ? NV : start_count;
      end
      CMD_ADD: begin
        if (!ok || u == v) o.status = ST_INVALID;
        else begin
          adj_rows[u][v] = 1'b1;
          adj_rows[v][u] = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!ok) o.status = ST_INVALID;
        else if (u != v) begin
          adj_rows[u][v] = 1'b0;
          adj_rows[v][u] = 1'b0;
        end
      end
      CMD_QUERY: begin
        if (!ok) o.status = ST_INVALID;
        else o.edge_present = adj_rows[u][v];
      end
      CMD_MERGE: begin
        if (!ok || u == v) o.status = ST_INVALID;
        else graph_merge(u, v);
      end
      CMD_CONTRACT: begin
        if (!ok || u == v || !adj_rows[u][v]) o.status = ST_INVALID;
        else graph_merge(u, v);
      end
      CMD_SPLIT: begin
        if (v >= live_count) o.status = ST_INVALID;
        else if (live_count >= NV) o.status = ST_FULL;
        else graph_split(v);
      end
      default: o.status = ST_INVALID;
    endcase
    o.vertex_count = live_count[CountWidth-1:0];
    return o;
  endfunction

  // one command word, with random idle before it unless quiet_sender is set
  task automatic send_word(input cmd_t c, input int unsigned u, input int unsigned v);
    in_word_t w;
    w.cmd = c;
    w.first_vertex = u[VertexWidth-1:0];
    w.second_vertex = v[VertexWidth-1:0];
    // the block is busy after accepting a word, so this costs nothing
    @(negedge clk);
    if (!quiet_sender) begin
      while ($urandom_range(99) < 12) @(negedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(predict_graph_step(w));
    @(negedge clk);
    start <= 1'b0;
    in_word <= in_word_t'($urandom);
  endtask

  task automatic wait_for_results();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start_count(input int unsigned value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value[CountWidth-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    start_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker: compare each strobed word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        out_word_t want;
        want = expected_words.pop_front();
        if (out_word.edge_present !== want.edge_present)
          report_mismatch("edge_present", out_word.edge_present, want.edge_present);
        if (out_word.vertex_count !== want.vertex_count)
          report_mismatch("vertex_count", out_word.vertex_count, want.vertex_count);
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
      end
    end
  end

  // watchdog: cycles with no accepted word, config write or result
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("graph_contract_split_engine_top verification failed");
        $finish;
      end
    end
  end

  // edge extremes, self edges, unknown command
  task automatic test_edge_ops();
    send_word(CMD_ADD, 0, 31);
    send_word(CMD_QUERY, 31, 0);
    send_word(CMD_ADD, 5, 5);
    send_word(CMD_QUERY, 5, 5);
    send_word(CMD_REMOVE, 5, 5);
    send_word(CMD_REMOVE, 3, 4);
    send_word(CMD_REMOVE, 0, 31);
    send_word(CMD_QUERY, 0, 31);
    send_word(CMD_NONE, 31, 31);
    send_word(CMD_ADD, 1, 2);
    send_word(CMD_ADD, 2, 3);
  endtask

  // full graph split, merges, contracts and empty start count
  task automatic test_merge_split();
    send_word(CMD_SPLIT, 2, 0);
    send_word(CMD_SPLIT, 0, 31);
    send_word(CMD_CONTRACT, 1, 3);
    send_word(CMD_CONTRACT, 1, 1);
    send_word(CMD_CONTRACT, 1, 2);
    send_word(CMD_MERGE, 4, 4);
    send_word(CMD_MERGE, 0, 30);
    send_word(CMD_SPLIT, 0, 1);
    send_word(CMD_SPLIT, 0, 31);
    send_word(CMD_QUERY, 30, 1);
    write_start_count(0);
    send_word(CMD_INIT, 0, 0);
    send_word(CMD_SPLIT, 0, 0);
    write_start_count(63);
    send_word(CMD_INIT, 31, 31);
  endtask

  // mostly well-formed commands on live vertices, with some noise
  task automatic test_random_commands(input int count);
    int unsigned lim, u, v, r;
    cmd_t c;
    for (int k = 0; k < count; k++) begin
      if (k == count / 3) quiet_sender = 1'b1;
      if (k == count / 2) quiet_sender = 1'b0;
      if (k % 300 == 150) begin
        write_start_count((k % 600 == 150) ? $urandom_range(1, 4) : $urandom_range(1, 63));
        send_word(CMD_INIT, $urandom, $urandom);
        continue;
      end
      lim = (live_count == 0) ? 0 : live_count - 1;
      u = ($urandom_range(99) < 8) ? $urandom_range(31) : $urandom_range(lim);
      v = ($urandom_range(99) < 8) ? $urandom_range(31) : $urandom_range(lim);
      r = $urandom_range(99);
      if (r < 30) c = CMD_ADD;
      else if (r < 40) c = CMD_REMOVE;
      else if (r < 55) c = CMD_QUERY;
      else if (r < 65) c = CMD_MERGE;
      else if (r < 77) c = CMD_CONTRACT;
      else if (r < 95) c = CMD_SPLIT;
      else if (r < 98) c = CMD_INIT;
      else c = CMD_NONE;
      send_word(c, u, v);
    end
  endtask

  initial begin
    int drain;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    error_count = 0;
    idle_cycles = 0;
    quiet_sender = 1'b0;
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    start_count = 32;
    live_count = 32;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_ops();
    test_merge_split();
    test_random_commands(1330);

    // let everything drain, bounded
    drain = 0;
    while (expected_words.size() != 0 && drain < WATCHDOG_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("graph_contract_split_engine_top verification clean");
    end else begin
      $display("graph_contract_split_engine_top verification failed");
    end
    $finish;
  end

endmodule
